### hw/rtl/triangle_centroid_normal_area_assert.svh
// Assertion macros for the triangle centroid, normal and area block.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef TRIANGLE_CENTROID_NORMAL_AREA_ASSERT_SVH
`define TRIANGLE_CENTROID_NORMAL_AREA_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TCNA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCNA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tcna_pkg.sv
// Shared types and constants of the triangle centroid, normal and area block.
// No dependencies; used by every module of the block but tcna_fifo.
`timescale 1ns / 1ps

package tcna_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
    } triangle_t;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [32:0]        face_area;
        logic               degenerate;
    } result_t;

    // Word passed from the front part to the back part.
    typedef struct packed {
        logic signed [34:0] cross_x;
        logic signed [34:0] cross_y;
        logic signed [34:0] cross_z;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic               degenerate;
    } mid_t;

endpackage

### hw/rtl/tcna_fifo.sv
// Small synchronous queue used between the front and back parts and at the output.
// Depends on nothing; width and depth come from the instantiating module.
`timescale 1ns / 1ps

module tcna_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             is_full,
    output logic             is_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/tcna_front.sv
// Front part: accepts triangles, forms edges, cross product and centroid,
// and flags degenerate faces. Depends on tcna_pkg.
`timescale 1ns / 1ps

module tcna_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tcna_pkg::triangle_t triangle,
    input  logic                mid_full,
    output logic                mid_push,
    output tcna_pkg::mid_t      mid_data
);

    // Division by six as a multiply by a rounded-up reciprocal; exact below 2^23.
    localparam logic [21:0] DIV6_RECIP = 22'd2796203;
    localparam int          DIV6_SHIFT = 24;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [15:0] av [3];
    logic signed [15:0] bv [3];
    logic signed [15:0] cv [3];

    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [17:0] sum_reg [3];

    logic signed [33:0] prod_reg [6];
    logic [17:0]        t_reg [3];
    logic [2:0]         neg2_reg;

    logic signed [34:0] cross_reg [3];
    logic [39:0]        cm_reg [3];
    logic [2:0]         neg3_reg;

    tcna_pkg::mid_t     mid_reg, mid_next;

    logic [17:0]        mag_sum [3];
    logic [15:0]        quot [3];
    logic signed [15:0] center [3];

    assign av[0] = triangle.a_x;
    assign av[1] = triangle.a_y;
    assign av[2] = triangle.a_z;
    assign bv[0] = triangle.b_x;
    assign bv[1] = triangle.b_y;
    assign bv[2] = triangle.b_z;
    assign cv[0] = triangle.c_x;
    assign cv[1] = triangle.c_y;
    assign cv[2] = triangle.c_z;

    assign en       = !(v4_reg && mid_full);
    assign full     = !en;
    assign mid_push = v4_reg && !mid_full;
    assign mid_data = mid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_sum[i] = sum_reg[i][17] ? 18'(-sum_reg[i]) : 18'(sum_reg[i]);
            quot[i]    = cm_reg[i][DIV6_SHIFT+15:DIV6_SHIFT];
            center[i]  = neg3_reg[i] ? -$signed(quot[i]) : $signed(quot[i]);
        end
        mid_next.cross_x    = cross_reg[0];
        mid_next.cross_y    = cross_reg[1];
        mid_next.cross_z    = cross_reg[2];
        mid_next.center_x   = center[0];
        mid_next.center_y   = center[1];
        mid_next.center_z   = center[2];
        mid_next.degenerate = (cross_reg[0] == '0) && (cross_reg[1] == '0)
                              && (cross_reg[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]  <= 17'(bv[i]) - 17'(av[i]);
                e2_reg[i]  <= 17'(cv[i]) - 17'(av[i]);
                sum_reg[i] <= 18'(av[i]) + 18'(bv[i]) + 18'(cv[i]);
                // Twice the magnitude plus three, so that one floor division by six
                // rounds to nearest with ties away from zero.
                t_reg[i]   <= {mag_sum[i][16:0], 1'b0} + 18'd3;
                neg2_reg[i] <= sum_reg[i][17];
                cm_reg[i]  <= 40'(t_reg[i]) * 40'(DIV6_RECIP);
                neg3_reg[i] <= neg2_reg[i];
            end
            prod_reg[0] <= e1_reg[1] * e2_reg[2];
            prod_reg[1] <= e1_reg[2] * e2_reg[1];
            prod_reg[2] <= e1_reg[2] * e2_reg[0];
            prod_reg[3] <= e1_reg[0] * e2_reg[2];
            prod_reg[4] <= e1_reg[0] * e2_reg[1];
            prod_reg[5] <= e1_reg[1] * e2_reg[0];
            cross_reg[0] <= 35'(prod_reg[0]) - 35'(prod_reg[1]);
            cross_reg[1] <= 35'(prod_reg[2]) - 35'(prod_reg[3]);
            cross_reg[2] <= 35'(prod_reg[4]) - 35'(prod_reg[5]);
            mid_reg <= mid_next;
        end
    end

endmodule

### hw/rtl/tcna_back.sv
// Back part: squared length, pipelined square root, three pipelined dividers
// for the unit normal, area, and the output queue. Depends on tcna_pkg, tcna_fifo.
`timescale 1ns / 1ps

module tcna_back #(
    parameter int OUT_DEPTH = tcna_pkg::OUT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mid_empty,
    output logic              mid_pop,
    input  tcna_pkg::mid_t    mid_data,
    output logic              empty,
    input  logic              pop,
    output tcna_pkg::result_t result
);

    localparam int SQ_STEPS = 36;
    localparam int Q_W      = 15;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [2:0]         neg;
        logic               degenerate;
    } side_t;

    logic en, oq_full, oq_push;

    logic v1_reg, v2_reg, v3_reg;
    logic sq_v_reg [SQ_STEPS+1];
    logic dv_v_reg [Q_W+1];

    logic signed [34:0] cross_in [3];
    logic [2:0]         neg_in;
    logic [33:0]        mag_in [3];
    side_t              side_in;

    logic [33:0] mag1_reg [3];
    side_t       side1_reg;
    logic [33:0] hh_reg [3];
    logic [33:0] hl_reg [3];
    logic [33:0] ll_reg [3];
    logic [33:0] mag2_reg [3];
    side_t       side2_reg;
    logic [67:0] sq_reg [3];
    logic [33:0] mag3_reg [3];
    side_t       side3_reg;

    logic [71:0] sq_s_reg    [SQ_STEPS+1];
    logic [38:0] sq_rem_reg  [SQ_STEPS+1];
    logic [35:0] sq_root_reg [SQ_STEPS+1];
    logic [33:0] sq_mag_reg  [SQ_STEPS+1][3];
    side_t       sq_side_reg [SQ_STEPS+1];

    logic [71:0] sq_s_next    [SQ_STEPS+1];
    logic [38:0] sq_rem_next  [SQ_STEPS+1];
    logic [35:0] sq_root_next [SQ_STEPS+1];
    logic [38:0] cand [SQ_STEPS];
    logic [38:0] trial [SQ_STEPS];

    logic [51:0]    dv_rem_reg [Q_W+1][3];
    logic [Q_W-1:0] dv_q_reg   [Q_W+1][3];
    logic [35:0]    dv_len_reg [Q_W+1];
    side_t          dv_side_reg [Q_W+1];

    logic [51:0]    dv_rem_next [Q_W+1][3];
    logic [Q_W-1:0] dv_q_next   [Q_W+1][3];
    logic [51:0]    dsh [Q_W][3];

    logic signed [15:0] normal [3];
    logic [32:0]        area;
    tcna_pkg::result_t  res_word;

    assign en      = !(dv_v_reg[Q_W] && oq_full);
    assign mid_pop = en && !mid_empty;
    assign oq_push = en && dv_v_reg[Q_W];

    assign cross_in[0] = mid_data.cross_x;
    assign cross_in[1] = mid_data.cross_y;
    assign cross_in[2] = mid_data.cross_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = cross_in[i][34];
            mag_in[i] = neg_in[i] ? 34'(-cross_in[i]) : 34'(cross_in[i]);
        end
        side_in.cx         = mid_data.center_x;
        side_in.cy         = mid_data.center_y;
        side_in.cz         = mid_data.center_z;
        side_in.neg        = neg_in;
        side_in.degenerate = mid_data.degenerate;
    end

    // Square root, one result bit per stage, from the top bit pair down.
    always_comb
    begin
        sq_s_next[0]    = '0;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            cand[i]  = {sq_rem_reg[i][36:0], sq_s_reg[i][71:70]};
            trial[i] = {1'b0, sq_root_reg[i], 2'b01};
            sq_s_next[i+1] = {sq_s_reg[i][69:0], 2'b00};
            if (cand[i] >= trial[i])
            begin
                sq_rem_next[i+1]  = cand[i] - trial[i];
                sq_root_next[i+1] = {sq_root_reg[i][34:0], 1'b1};
            end
            else
            begin
                sq_rem_next[i+1]  = cand[i];
                sq_root_next[i+1] = {sq_root_reg[i][34:0], 1'b0};
            end
        end
    end

    // Restoring division of (|C| * 2^15 + L) by 2L, quotient bits from the top.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_next[0][i] = 52'({sq_mag_reg[SQ_STEPS][i], 15'b0})
                                + 52'(sq_root_reg[SQ_STEPS]);
            dv_q_next[0][i]   = '0;
        end
        for (int j = 0; j < Q_W; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dsh[j][i] = 52'({dv_len_reg[j], 1'b0}) << (Q_W - 1 - j);
                if (dv_rem_reg[j][i] >= dsh[j][i])
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i] - dsh[j][i];
                    dv_q_next[j+1][i]   = dv_q_reg[j][i] | (Q_W'(1) << (Q_W - 1 - j));
                end
                else
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i];
                    dv_q_next[j+1][i]   = dv_q_reg[j][i];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side_reg[Q_W].degenerate)
            begin
                normal[i] = '0;
            end
            else if (dv_side_reg[Q_W].neg[i])
            begin
                normal[i] = -$signed(16'(dv_q_reg[Q_W][i]));
            end
            else
            begin
                normal[i] = $signed(16'(dv_q_reg[Q_W][i]));
            end
        end
        area = dv_side_reg[Q_W].degenerate ? '0
               : 33'((37'(dv_len_reg[Q_W]) + 37'd1) >> 1);
        res_word.center_x   = dv_side_reg[Q_W].cx;
        res_word.center_y   = dv_side_reg[Q_W].cy;
        res_word.center_z   = dv_side_reg[Q_W].cz;
        res_word.normal_x   = normal[0];
        res_word.normal_y   = normal[1];
        res_word.normal_z   = normal[2];
        res_word.face_area  = area;
        res_word.degenerate = dv_side_reg[Q_W].degenerate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            for (int j = 0; j <= Q_W; j++)
            begin
                dv_v_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg      <= !mid_empty;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            sq_v_reg[0] <= v3_reg;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
            for (int j = 0; j < Q_W; j++)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag_in[i];
                // Each 34-bit square is built from 17-bit halves.
                hh_reg[i]   <= mag1_reg[i][33:17] * mag1_reg[i][33:17];
                hl_reg[i]   <= mag1_reg[i][33:17] * mag1_reg[i][16:0];
                ll_reg[i]   <= mag1_reg[i][16:0] * mag1_reg[i][16:0];
                mag2_reg[i] <= mag1_reg[i];
                sq_reg[i]   <= (68'(hh_reg[i]) << 34) + (68'(hl_reg[i]) << 18)
                               + 68'(ll_reg[i]);
                mag3_reg[i] <= mag2_reg[i];
                sq_mag_reg[0][i] <= mag3_reg[i];
            end
            sq_s_reg[0]    <= 72'(69'(sq_reg[0]) + 69'(sq_reg[1]) + 69'(sq_reg[2]));
            sq_rem_reg[0]  <= sq_rem_next[0];
            sq_root_reg[0] <= sq_root_next[0];
            sq_side_reg[0] <= side3_reg;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                sq_s_reg[i+1]    <= sq_s_next[i+1];
                sq_rem_reg[i+1]  <= sq_rem_next[i+1];
                sq_root_reg[i+1] <= sq_root_next[i+1];
                sq_side_reg[i+1] <= sq_side_reg[i];
                sq_mag_reg[i+1]  <= sq_mag_reg[i];
            end
            dv_len_reg[0]  <= sq_root_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
            for (int j = 0; j <= Q_W; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end
            for (int j = 0; j < Q_W; j++)
            begin
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    tcna_fifo #(
        .WIDTH ($bits(tcna_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (oq_push),
        .wr_data  (res_word),
        .rd_en    (pop),
        .rd_data  (result),
        .is_full  (oq_full),
        .is_empty (empty)
    );

endmodule

### hw/rtl/triangle_centroid_normal_area.sv
// Top level of the triangle centroid, normal and area block.
// Depends on tcna_pkg, tcna_front, tcna_fifo and tcna_back.
`timescale 1ns / 1ps

// Usage
// Input side: drive a triangle word and raise push; it is taken at a rising edge
// where full is low. Output side: while empty is low the oldest result word is on
// result, and it is taken at a rising edge where pop is high.
// Throughput is one triangle per cycle when the receiver keeps up.
// The path from acceptance to the word appearing on result runs through four
// front stages, the middle queue, 56 back stages (squares, 36 square-root steps,
// 15 divider steps) and the output queue.
// The square root and the three normal dividers each resolve one bit per stage,
// which sets the depth.
// When the receiver stalls, the output queue fills, the back pipeline holds, the
// middle queue fills, then the front holds and full rises; no word is lost.
// Reset empties both queues and clears every stage valid flag; full is low and
// empty is high straight after reset.
module triangle_centroid_normal_area #(
    parameter int MID_DEPTH = tcna_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = tcna_pkg::OUT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tcna_pkg::triangle_t triangle,
    output logic                empty,
    input  logic                pop,
    output tcna_pkg::result_t   result
);

    logic           mid_push, mid_pop, mid_full, mid_empty;
    tcna_pkg::mid_t mid_wr, mid_rd;

    tcna_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .triangle (triangle),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_data (mid_wr)
    );

    tcna_fifo #(
        .WIDTH ($bits(tcna_pkg::mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mid_push),
        .wr_data  (mid_wr),
        .rd_en    (mid_pop),
        .rd_data  (mid_rd),
        .is_full  (mid_full),
        .is_empty (mid_empty)
    );

    tcna_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### hw/rtl/tcna_checker.sv
// Port checker for the triangle centroid, normal and area block, bound to the top.
// Depends on tcna_pkg and triangle_centroid_normal_area_assert.svh.
`timescale 1ns / 1ps
`include "triangle_centroid_normal_area_assert.svh"

module tcna_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input tcna_pkg::result_t result
);

    // A degenerate face carries a zero normal and zero area.
    `TCNA_ASSERT(a_degen_zero, !empty && result.degenerate |-> result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0 && result.face_area == 0, "degenerate word with nonzero normal or area")

    // Any real face has at least one unit of area.
    `TCNA_ASSERT(a_area_nonzero, !empty && !result.degenerate |-> result.face_area != 0, "non-degenerate word with zero area")

    `TCNA_ASSERT(a_normal_range, !empty |-> result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 && result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 && result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384, "normal component out of range")

    `TCNA_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(result), "waiting result word changed")

    // After reset is seen low at a clock edge, the queues are clear and the input side is open.
    `TCNA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty && !full, "queues not cleared in reset")

endmodule

bind triangle_centroid_normal_area tcna_checker u_tcna_checker (.*);
